// ----- hdl/mfbr_pkg.sv -----
// Shared types and constants of the MSB-first bit reader.
// Used by the front end, back end and top level; depends on nothing else.
package mfbr_pkg;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_UNDERFLOW = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_WIDE      = 2'd3;

   localparam logic [5:0] MAX_BITS = 6'd32;

   localparam int CMD_Q_DEPTH = 2;
   localparam int RSP_Q_DEPTH = 4;
   localparam int RSP_LEVEL_W = $clog2(RSP_Q_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_PUSH,
      CMD_READ,
      CMD_CLEAR,
      CMD_NOP,
      CMD_WIDE
   } cmd_kind_type;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_SHORT,
      MODE_LONG,
      MODE_CLEAR
   } exec_mode_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   byte_in;
      logic [5:0]   num_bits;
   } cmd_type;

   typedef struct packed {
      exec_mode_type mode;
      logic [1:0]    status;
      logic [5:0]    shift;
      logic [5:0]    num_bits;
      logic [2:0]    nbytes;
      logic [1:0]    lane;
      logic [2:0]    bits_to_align;
   } stage_type;

   typedef struct packed {
      logic [31:0] field_value;
      logic [1:0]  status;
      logic [2:0]  bits_to_align;
   } rsp_type;

endpackage

// ----- hdl/mfbr_fifo.sv -----
// Small flop-based queue with push/pop handshake and a fill level.
// Used for the command queue and the result queue; no package dependency.
module mfbr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           rd_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             wr_en, rd_en;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign level   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign wr_en   = push && !full;
   assign rd_en   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (rd_en) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (wr_en && !rd_en) begin
         count_in = count_ff + 1'b1;
      end else if (rd_en && !wr_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hdl/mfbr_front.sv -----
// Front end: accepts items, classifies them into commands, and queues them.
// Depends on mfbr_pkg and mfbr_fifo.
module mfbr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  logic [1:0]        opcode,
   input  logic [7:0]        byte_in,
   input  logic [5:0]        num_bits,
   output logic              cmd_valid,
   output mfbr_pkg::cmd_type cmd,
   input  logic              cmd_pop
);

   mfbr_pkg::cmd_type cmd_new;
   logic [$bits(mfbr_pkg::cmd_type)-1:0] cmd_bits;
   logic cmd_empty;
   logic [$clog2(mfbr_pkg::CMD_Q_DEPTH+1)-1:0] cmd_level;

   always_comb begin
      cmd_new.byte_in  = byte_in;
      cmd_new.num_bits = num_bits;
      case (opcode)
         mfbr_pkg::OP_PUSH: begin
            cmd_new.kind = mfbr_pkg::CMD_PUSH;
         end
         mfbr_pkg::OP_READ: begin
            cmd_new.kind = (num_bits > mfbr_pkg::MAX_BITS) ? mfbr_pkg::CMD_WIDE
                                                            : mfbr_pkg::CMD_READ;
         end
         mfbr_pkg::OP_CLEAR: begin
            cmd_new.kind = mfbr_pkg::CMD_CLEAR;
         end
         default: begin
            cmd_new.kind = mfbr_pkg::CMD_NOP;
         end
      endcase
   end

   mfbr_fifo #(
      .WIDTH($bits(mfbr_pkg::cmd_type)),
      .DEPTH(mfbr_pkg::CMD_Q_DEPTH)
   ) u_cmd_q (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .wr_data(cmd_new),
      .pop    (cmd_pop),
      .rd_data(cmd_bits),
      .full   (full),
      .empty  (cmd_empty),
      .level  (cmd_level)
   );

   assign cmd       = mfbr_pkg::cmd_type'(cmd_bits);
   assign cmd_valid = !cmd_empty && (cmd_level != '0);

endmodule

// ----- hdl/mfbr_back.sv -----
// Back end: byte buffer in four banks, held-bit bookkeeping and field assembly.
// Depends on mfbr_pkg.
module mfbr_back #(
   parameter int BUF_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                cmd_valid,
   input  mfbr_pkg::cmd_type                   cmd,
   output logic                                cmd_pop,
   input  logic [mfbr_pkg::RSP_LEVEL_W-1:0]    rsp_level,
   output logic                                rsp_push,
   output mfbr_pkg::rsp_type                   rsp_item
);

   localparam int ROWS  = (BUF_DEPTH + 3) / 4;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int CNT_W = $clog2(BUF_DEPTH + 1);
   localparam int LVL_W = mfbr_pkg::RSP_LEVEL_W + 1;

   logic [2:0]       hc_ff, hc_in;
   logic [ROW_W-1:0] rrow_ff, rrow_in, wrow_ff, wrow_in, rrow_next;
   logic [1:0]       rlane_ff, rlane_in, wlane_ff, wlane_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             b_valid_ff;
   mfbr_pkg::stage_type stage_ff, stage_in;
   logic [7:0]       held_byte_ff, held_byte_in;
   logic [7:0]       bank_q_ff [4];
   logic             wr_en;
   logic             fire;
   logic [5:0]       rest;
   logic [2:0]       nbytes;
   logic [2:0]       lane_sum;
   logic [7:0]       bytes [4];
   logic [39:0]      window;
   logic [39:0]      shifted;
   logic [32:0]      mask;

   assign fire = cmd_valid && ((LVL_W'(rsp_level) + LVL_W'(b_valid_ff))
                               < LVL_W'(mfbr_pkg::RSP_Q_DEPTH));
   assign cmd_pop = fire;
   assign rrow_next = (rrow_ff == ROW_W'(ROWS - 1)) ? '0 : rrow_ff + 1'b1;

   always_comb begin
      hc_in    = hc_ff;
      rrow_in  = rrow_ff;
      rlane_in = rlane_ff;
      wrow_in  = wrow_ff;
      wlane_in = wlane_ff;
      count_in = count_ff;
      wr_en    = 1'b0;
      rest     = cmd.num_bits - {3'b000, hc_ff};
      nbytes   = 3'((rest - 6'd1) >> 3) + 3'd1;
      lane_sum = {1'b0, rlane_ff} + nbytes;
      stage_in.mode     = mfbr_pkg::MODE_NONE;
      stage_in.status   = mfbr_pkg::ST_OK;
      stage_in.shift    = 6'd32 + {3'b000, hc_ff} - cmd.num_bits;
      stage_in.num_bits = cmd.num_bits;
      stage_in.nbytes   = nbytes;
      stage_in.lane     = rlane_ff;
      case (cmd.kind)
         mfbr_pkg::CMD_PUSH: begin
            if (count_ff == CNT_W'(BUF_DEPTH)) begin
               stage_in.status = mfbr_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
               wlane_in = wlane_ff + 2'd1;
               if (wlane_ff == 2'd3) begin
                  wrow_in = (wrow_ff == ROW_W'(ROWS - 1)) ? '0 : wrow_ff + 1'b1;
               end
            end
         end
         mfbr_pkg::CMD_READ: begin
            if (cmd.num_bits <= {3'b000, hc_ff}) begin
               stage_in.mode = mfbr_pkg::MODE_SHORT;
               hc_in = hc_ff - cmd.num_bits[2:0];
            end else if (count_ff < CNT_W'(nbytes)) begin
               stage_in.status = mfbr_pkg::ST_UNDERFLOW;
            end else begin
               stage_in.mode = mfbr_pkg::MODE_LONG;
               hc_in    = 3'(6'd0 - rest);
               count_in = count_ff - CNT_W'(nbytes);
               rlane_in = lane_sum[1:0];
               if (lane_sum[2]) begin
                  rrow_in = rrow_next;
               end
            end
         end
         mfbr_pkg::CMD_CLEAR: begin
            stage_in.mode = mfbr_pkg::MODE_CLEAR;
            hc_in    = '0;
            rrow_in  = '0;
            rlane_in = '0;
            wrow_in  = '0;
            wlane_in = '0;
            count_in = '0;
         end
         mfbr_pkg::CMD_WIDE: begin
            stage_in.status = mfbr_pkg::ST_WIDE;
         end
         default: begin
            stage_in.mode = mfbr_pkg::MODE_NONE;
         end
      endcase
      stage_in.bits_to_align = hc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hc_ff        <= '0;
         rrow_ff      <= '0;
         rlane_ff     <= '0;
         wrow_ff      <= '0;
         wlane_ff     <= '0;
         count_ff     <= '0;
         b_valid_ff   <= 1'b0;
         held_byte_ff <= '0;
      end else begin
         b_valid_ff <= fire;
         if (fire) begin
            hc_ff    <= hc_in;
            rrow_ff  <= rrow_in;
            rlane_ff <= rlane_in;
            wrow_ff  <= wrow_in;
            wlane_ff <= wlane_in;
            count_ff <= count_in;
         end
         if (b_valid_ff) begin
            held_byte_ff <= held_byte_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         stage_ff <= stage_in;
      end
   end

   // Bank b holds the bytes whose buffer position is b modulo four.
   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [7:0]       mem [ROWS];
      logic [ROW_W-1:0] rd_row;

      assign rd_row = (2'(b) < rlane_ff) ? rrow_next : rrow_ff;

      always_ff @(posedge clock) begin
         if (fire && wr_en && (wlane_ff == 2'(b))) begin
            mem[wrow_ff] <= cmd.byte_in;
         end
         if (fire) begin
            bank_q_ff[b] <= mem[rd_row];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 4; j++) begin
         bytes[j] = bank_q_ff[stage_ff.lane + 2'(j)];
      end
      window  = {held_byte_ff, bytes[0], bytes[1], bytes[2], bytes[3]};
      shifted = window >> stage_ff.shift;
      mask    = (33'd1 << stage_ff.num_bits) - 33'd1;
      held_byte_in = held_byte_ff;
      rsp_item.field_value   = '0;
      rsp_item.status        = stage_ff.status;
      rsp_item.bits_to_align = stage_ff.bits_to_align;
      case (stage_ff.mode)
         mfbr_pkg::MODE_SHORT: begin
            rsp_item.field_value = shifted[31:0] & mask[31:0];
         end
         mfbr_pkg::MODE_LONG: begin
            rsp_item.field_value = shifted[31:0] & mask[31:0];
            held_byte_in = bytes[stage_ff.nbytes[1:0] - 2'd1];
         end
         mfbr_pkg::MODE_CLEAR: begin
            held_byte_in = '0;
         end
         default: begin
            held_byte_in = held_byte_ff;
         end
      endcase
   end

   assign rsp_push = b_valid_ff;

endmodule

// ----- hdl/msb_first_bit_reader_top.sv -----
// Top level of the MSB-first bit reader: front end, back end and result queue.
// Depends on mfbr_pkg, mfbr_front, mfbr_back and mfbr_fifo.
//
// The reader takes one item per clock cycle while req_full is low: a byte push,
// a field read of 0 to 32 bits (a wider one gets ST_WIDE), a clear or a no-op,
// and returns exactly one result per item. The back end keeps the byte buffer
// in four banks so a read pulls up to four bytes at once; held-bit bookkeeping
// finishes as a command issues and the field is assembled in the following
// cycle. A command queue of two entries and a result queue of four entries let
// both sides stall independently; full rises only when both queues are backed
// up.
module msb_first_bit_reader_top #(
   parameter int BUF_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_byte_in,
   input  logic [5:0]  req_num_bits,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_field_value,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_bits_to_align
);

   logic              cmd_valid;
   logic              cmd_pop;
   mfbr_pkg::cmd_type cmd;
   logic              rsp_push;
   mfbr_pkg::rsp_type rsp_item;
   mfbr_pkg::rsp_type rsp_head;
   logic [$bits(mfbr_pkg::rsp_type)-1:0] rsp_bits;
   logic              rsp_q_full;
   logic [mfbr_pkg::RSP_LEVEL_W-1:0] rsp_level;

   mfbr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (req_push),
      .full     (req_full),
      .opcode   (req_opcode),
      .byte_in  (req_byte_in),
      .num_bits (req_num_bits),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop)
   );

   mfbr_back #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(cmd_valid),
      .cmd      (cmd),
      .cmd_pop  (cmd_pop),
      .rsp_level(rsp_level),
      .rsp_push (rsp_push),
      .rsp_item (rsp_item)
   );

   mfbr_fifo #(
      .WIDTH($bits(mfbr_pkg::rsp_type)),
      .DEPTH(mfbr_pkg::RSP_Q_DEPTH)
   ) u_rsp_q (
      .clock  (clock),
      .reset  (reset),
      .push   (rsp_push),
      .wr_data(rsp_item),
      .pop    (rsp_pop),
      .rd_data(rsp_bits),
      .full   (rsp_q_full),
      .empty  (rsp_empty),
      .level  (rsp_level)
   );

   assign rsp_head          = mfbr_pkg::rsp_type'(rsp_bits);
   assign rsp_field_value   = rsp_head.field_value;
   assign rsp_status        = rsp_head.status;
   assign rsp_bits_to_align = rsp_head.bits_to_align;

   a_no_rsp_overflow : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_q_full)
      else $error("Result queue written while full.");

   a_issue_gives_result : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> rsp_push)
      else $error("Issued command produced no result.");

   a_error_zero_value : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_status != mfbr_pkg::ST_OK)) |-> (rsp_field_value == 32'd0))
      else $error("Failed transfer carries a nonzero field value.");

endmodule

// ----- test/tb_msb_first_bit_reader_top.sv -----
// Self-checking testbench for msb_first_bit_reader_top: pushes, field reads, clears and no-ops.
// Depends on mfbr_pkg and the reader RTL; predicts every result with its own bit reader model.
module tb_msb_first_bit_reader_top;

   localparam int BUF_DEPTH = 16;
   localparam logic [1:0] OP_NOP = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [1:0]  req_opcode = OP_NOP;
   logic [7:0]  req_byte_in = 8'd0;
   logic [5:0]  req_num_bits = 6'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [31:0] rsp_field_value;
   logic [1:0]  rsp_status;
   logic [2:0]  rsp_bits_to_align;

   logic [7:0]  shadow_bytes [BUF_DEPTH];
   logic [7:0]  shadow_held_byte = 8'd0;
   int          shadow_held_bits = 0;
   int          shadow_rd = 0;
   int          shadow_wr = 0;
   int          shadow_level = 0;

   mfbr_pkg::rsp_type pending_fields [$];
   bit          idle_enable = 1'b1;
   int          stall_left = 0;
   int          error_count = 0;
   int          items_sent = 0;
   int          results_checked = 0;
   int          underflow_seen = 0;
   int          full_seen = 0;

   msb_first_bit_reader_top #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_opcode(req_opcode),
      .req_byte_in(req_byte_in),
      .req_num_bits(req_num_bits),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_field_value(rsp_field_value),
      .rsp_status(rsp_status),
      .rsp_bits_to_align(rsp_bits_to_align)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("msb_first_bit_reader_top verification failed");
      $finish;
   end

   function automatic int unsigned low_bits(input int n);
      logic [63:0] m;
      m = (64'd1 << n) - 64'd1;
      return m[31:0];
   endfunction

   function automatic void predict_result(input logic [1:0] op, input logic [7:0] data,
                                          input logic [5:0] bits);
      mfbr_pkg::rsp_type r;
      int           rest;
      int           nbytes;
      int           next_held;
      logic [63:0]  acc;
      int unsigned  word;
      r = '0;
      case (op)
         mfbr_pkg::OP_PUSH: begin
            if (shadow_level >= BUF_DEPTH) begin
               r.status = mfbr_pkg::ST_FULL;
            end else begin
               shadow_bytes[shadow_wr] = data;
               shadow_wr = (shadow_wr + 1) % BUF_DEPTH;
               shadow_level++;
            end
         end
         mfbr_pkg::OP_READ: begin
            if (bits > mfbr_pkg::MAX_BITS) begin
               r.status = mfbr_pkg::ST_WIDE;
            end else if (int'(bits) <= shadow_held_bits) begin
               r.field_value = (int'(shadow_held_byte) >> (shadow_held_bits - int'(bits)))
                               & low_bits(bits);
               shadow_held_bits -= int'(bits);
            end else begin
               rest = int'(bits) - shadow_held_bits;
               nbytes = ((rest - 1) >> 3) + 1;
               if (shadow_level < nbytes) begin
                  r.status = mfbr_pkg::ST_UNDERFLOW;
               end else begin
                  acc = 64'(int'(shadow_held_byte) & low_bits(shadow_held_bits)) << rest;
                  word = 0;
                  next_held = (32 - rest) % 8;
                  for (int i = 0; i < nbytes; i++) begin
                     word = (word << 8) | shadow_bytes[shadow_rd];
                     shadow_rd = (shadow_rd + 1) % BUF_DEPTH;
                     shadow_level--;
                  end
                  acc = acc | 64'(word >> next_held);
                  r.field_value = acc[31:0];
                  shadow_held_bits = next_held;
                  shadow_held_byte = word[7:0];
               end
            end
         end
         mfbr_pkg::OP_CLEAR: begin
            shadow_held_byte = 8'd0;
            shadow_held_bits = 0;
            shadow_rd = 0;
            shadow_wr = 0;
            shadow_level = 0;
         end
         default: begin
         end
      endcase
      r.bits_to_align = 3'(shadow_held_bits);
      if (r.status == mfbr_pkg::ST_UNDERFLOW) underflow_seen++;
      if (r.status == mfbr_pkg::ST_FULL) full_seen++;
      pending_fields.push_back(r);
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic [5:0] bits);
      int gap;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= op;
      req_byte_in <= data;
      req_num_bits <= bits;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_result(op, data, bits);
      items_sent++;
   endtask

   task automatic run_stream(input int n_items);
      int sent;
      int burst;
      int avail;
      int n;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 8);
         repeat (burst) begin
            send_item(mfbr_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)));
            sent++;
         end
         burst = $urandom_range(1, 6);
         repeat (burst) begin
            avail = shadow_held_bits + 8 * shadow_level;
            case ($urandom_range(0, 9))
               0: n = $urandom_range(33, 63);
               1: n = $urandom_range(0, 32);
               default: n = $urandom_range(0, (avail < 32) ? avail : 32);
            endcase
            send_item(mfbr_pkg::OP_READ, 8'($urandom_range(0, 255)), 6'(n));
            sent++;
         end
         if ($urandom_range(0, 14) == 0) begin
            send_item(mfbr_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)));
            sent++;
         end
         if ($urandom_range(0, 14) == 0) begin
            send_item(OP_NOP, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
            sent++;
         end
      end
   endtask

   task automatic test_directed();
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd0);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd1);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd33);
      send_item(mfbr_pkg::OP_READ, 8'hFF, 6'd63);
      send_item(OP_NOP, 8'hFF, 6'd63);
      send_item(mfbr_pkg::OP_PUSH, 8'h00, 6'd0);
      send_item(mfbr_pkg::OP_PUSH, 8'hFF, 6'd0);
      send_item(mfbr_pkg::OP_PUSH, 8'hA5, 6'd0);
      send_item(mfbr_pkg::OP_PUSH, 8'h5A, 6'd0);
      send_item(mfbr_pkg::OP_PUSH, 8'h81, 6'd0);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd32);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd3);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd5);
      send_item(mfbr_pkg::OP_PUSH, 8'hC3, 6'd0);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd1);
      send_item(mfbr_pkg::OP_PUSH, 8'h3C, 6'd0);
      send_item(mfbr_pkg::OP_PUSH, 8'hE7, 6'd0);
      send_item(mfbr_pkg::OP_PUSH, 8'h18, 6'd0);
      send_item(mfbr_pkg::OP_PUSH, 8'h99, 6'd0);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd32);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd7);
      send_item(mfbr_pkg::OP_PUSH, 8'h77, 6'd0);
      send_item(mfbr_pkg::OP_CLEAR, 8'h00, 6'd0);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd8);
      send_item(mfbr_pkg::OP_READ, 8'h00, 6'd0);
   endtask

   task automatic test_random_mix(input int n_items);
      int sel;
      repeat (n_items) begin
         sel = $urandom_range(0, 19);
         if (sel < 8) begin
            send_item(mfbr_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)));
         end else if (sel < 16) begin
            send_item(mfbr_pkg::OP_READ, 8'($urandom_range(0, 255)),
                      6'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                                     : $urandom_range(0, 32)));
         end else if (sel < 18) begin
            send_item(mfbr_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)));
         end else begin
            send_item(OP_NOP, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)));
         end
      end
   endtask

   task automatic test_buffer_full();
      repeat (4) begin
         send_item(mfbr_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                   6'($urandom_range(0, 63)));
         repeat (BUF_DEPTH + 2) begin
            send_item(mfbr_pkg::OP_PUSH, 8'($urandom_range(0, 255)),
                      6'($urandom_range(0, 63)));
         end
         repeat (5) begin
            send_item(mfbr_pkg::OP_READ, 8'($urandom_range(0, 255)),
                      6'($urandom_range(25, 32)));
         end
      end
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      run_stream(150);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 8) - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      mfbr_pkg::rsp_type exp_r;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_fields.size() == 0) begin
            $error("Unexpected result transfer: field_value %h, status %0d, bits_to_align %0d",
                   rsp_field_value, rsp_status, rsp_bits_to_align);
            error_count++;
         end else begin
            exp_r = pending_fields.pop_front();
            results_checked++;
            if (rsp_field_value !== exp_r.field_value) begin
               $error("field_value mismatch: expected %h, actual %h",
                      exp_r.field_value, rsp_field_value);
               error_count++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status mismatch: expected %0d, actual %0d", exp_r.status, rsp_status);
               error_count++;
            end
            if (rsp_bits_to_align !== exp_r.bits_to_align) begin
               $error("bits_to_align mismatch: expected %0d, actual %0d",
                      exp_r.bits_to_align, rsp_bits_to_align);
               error_count++;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < BUF_DEPTH; i++) shadow_bytes[i] = 8'd0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_mix(250);
      run_stream(300);
      test_buffer_full();
      test_back_to_back();
      req_push <= 1'b0;
      while (pending_fields.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d items and checked %0d results, including %0d underflows",
               items_sent, results_checked, underflow_seen);
      $display("and %0d full pushes; covered pushes, reads of 0 to 63 bits, clears and no-ops.",
               full_seen);
      if (error_count == 0) begin
         $display("msb_first_bit_reader_top verification clean");
      end else begin
         $display("msb_first_bit_reader_top verification failed");
      end
      $finish;
   end

endmodule
